/* hw/rtl/sdl_pkg.sv */
// Shared types and constants of the SPH density and lambda block.
package sdl_pkg;

  // Sequencer states of the top level
  typedef enum logic [4:0] {
    ST_IDLE, ST_SEED, ST_P1, ST_P2, ST_P3, ST_P4, ST_NB, ST_H2, ST_RX, ST_RY,
    ST_CMP, ST_SQRT, ST_HR, ST_SPK, ST_DIV, ST_GX, ST_GY, ST_SQX, ST_SQY,
    ST_ACC, ST_LAST, ST_LPROD, ST_LSX, ST_LSY, ST_LINV, ST_LDEN, ST_LDIV, ST_OUT
  } st_t;

  // Phases of the serial arithmetic unit
  typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_FIN} phase_t;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} op_t;

  // Right shift applied to a full product
  typedef enum logic [2:0] {SH_0, SH_F, SH_2F, SH_24, SH_24F} shift_t;

  // Saturation bound applied to a shifted product
  typedef enum logic [1:0] {CAP_FULL, CAP_DENS, CAP_GRAD, CAP_BIG} cap_t;

  typedef struct packed {
    logic   start;
    op_t    op;
    shift_t sh;
    cap_t   cap;
  } arith_ctl_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY6   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RHO = 3'd4;

  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX47 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] BIG62 = 64'h4000_0000_0000_0000;

  localparam int COEF_FRAC  = 24;
  localparam int MUL_STEPS  = 64;
  localparam int DIV_STEPS  = 128;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 7;

endpackage

/* hw/rtl/sdl_if.sv */
// Request and result channel interfaces of the SPH density and lambda block.
interface sdl_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic               neighbor_valid;
  logic               last;

  modport source (output valid, pos_x, pos_y, neighbor_x, neighbor_y,
                  neighbor_valid, last, input ready);
  modport sink (input valid, pos_x, pos_y, neighbor_x, neighbor_y,
                neighbor_valid, last, output ready);
endinterface

interface sdl_result_if;
  logic               valid;
  logic               ready;
  logic        [31:0] density;
  logic signed [31:0] lambda;

  modport source (output valid, density, lambda, input ready);
  modport sink (input valid, density, lambda, output ready);
endinterface

/* hw/rtl/sdl_arith.sv */
// Bit-serial multiply, restoring divide and square root unit with saturation.
module sdl_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sdl_pkg::arith_ctl_t ctl,
  input  logic [127:0]        opa,
  input  logic [63:0]         opb,
  output logic                done,
  output logic [63:0]         res,
  output logic                res_hi_nz
);
  import sdl_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  op_t                op_q;
  shift_t             sh_q;
  cap_t               cap_q;
  logic [CNT_W-1:0]   cnt;
  logic [127:0]       acc;
  logic [63:0]        aux;
  logic [63:0]        rem;
  logic [63:0]        bitm;

  logic [64:0]        mul_sum;
  logic [64:0]        div_sh;
  logic [64:0]        div_dif;
  logic               div_ge;
  logic [63:0]        sq_try;
  logic               sq_ge;
  logic [127:0]       shifted;
  logic [63:0]        cap_v;
  logic [63:0]        mul_res;
  logic [63:0]        fin_res;

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == PH_FIN);
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (ctl.start) phase_next = PH_RUN;
      PH_RUN:  if (cnt == '0) phase_next = PH_FIN;
      PH_FIN:  phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // One bit of each operation per step
  always_comb begin
    mul_sum = {1'b0, acc[127:64]} + (acc[0] ? {1'b0, aux} : 65'd0);
    div_sh  = {rem, acc[127]};
    div_ge  = (div_sh >= {1'b0, aux});
    div_dif = div_sh - {1'b0, aux};
    sq_try  = aux + bitm;
    sq_ge   = (rem >= sq_try);
  end

  // Shift and saturate the finished product, and pick each operation's result
  always_comb begin
    unique case (sh_q)
      SH_0:    shifted = acc;
      SH_F:    shifted = acc >> FRAC_BITS;
      SH_2F:   shifted = acc >> (2 * FRAC_BITS);
      SH_24:   shifted = acc >> COEF_FRAC;
      SH_24F:  shifted = acc >> (COEF_FRAC + FRAC_BITS);
      default: shifted = acc;
    endcase
    unique case (cap_q)
      CAP_FULL: cap_v = MAX64;
      CAP_DENS: cap_v = MAX48;
      CAP_GRAD: cap_v = MAX47;
      CAP_BIG:  cap_v = BIG62;
      default:  cap_v = MAX64;
    endcase
    if (shifted[127:64] != '0 || shifted[63:0] > cap_v) begin
      mul_res = cap_v;
    end else begin
      mul_res = shifted[63:0];
    end
    unique case (op_q)
      OP_MUL:  fin_res = mul_res;
      OP_DIV:  fin_res = acc[63:0];
      OP_SQRT: fin_res = aux;
      default: fin_res = '0;
    endcase
  end

  // Load operands, then advance one step per cycle
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && ctl.start) begin
      op_q  <= ctl.op;
      sh_q  <= ctl.sh;
      cap_q <= ctl.cap;
      unique case (ctl.op)
        OP_MUL: begin
          acc <= {64'd0, opb};
          aux <= opa[63:0];
          cnt <= CNT_W'(MUL_STEPS - 1);
        end
        OP_DIV: begin
          acc <= opa;
          aux <= opb;
          rem <= '0;
          cnt <= CNT_W'(DIV_STEPS - 1);
        end
        OP_SQRT: begin
          rem  <= opa[63:0];
          aux  <= '0;
          bitm <= 64'd1 << 62;
          cnt  <= CNT_W'(SQRT_STEPS - 1);
        end
        default: cnt <= '0;
      endcase
    end else if (phase == PH_RUN) begin
      cnt <= cnt - 1'b1;
      unique case (op_q)
        OP_MUL: acc <= {mul_sum, acc[63:1]};
        OP_DIV: begin
          acc <= {acc[126:0], div_ge};
          rem <= div_ge ? div_dif[63:0] : div_sh[63:0];
        end
        OP_SQRT: begin
          if (sq_ge) begin
            rem <= rem - sq_try;
            aux <= (aux >> 1) + bitm;
          end else begin
            aux <= aux >> 1;
          end
          bitm <= bitm >> 2;
        end
        default: ;
      endcase
    end
  end

  // Hold the result for the sequencer
  always_ff @(posedge clk) begin
    if (phase == PH_FIN) begin
      res       <= fin_res;
      res_hi_nz <= |acc[127:64];
    end
  end

endmodule

/* hw/rtl/sph_density_lambda.sv */
// Top level of the SPH density and lambda block: sequencer and accumulators.
// Each request is handled alone; ready is high only while the sequencer idles.
// All arithmetic runs through one bit-serial unit (multiply 64 steps, divide
// 128 steps, square root 32 steps), so that unit sets the rate. The first
// request of a run adds the self term. A neighbor within reach runs the full
// density and gradient chain, one rejected on distance only the squared radius
// and distance, and one rejected on a single axis or an empty request skips the
// unit altogether. A request with last set adds the lambda steps.
// The result sits in an output register, so the next request is taken while a
// result waits; a further result waits until that register is free.
module sph_density_lambda #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  sdl_item_if.sink                       item,
  sdl_result_if.source                   result,
  input  logic                           cfg_wr_en,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import sdl_pkg::*;

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  // Configuration
  logic [30:0]        radius;
  logic [31:0]        poly6_coef;
  logic [31:0]        spiky_coef;
  logic [31:0]        mass_coef;
  logic [31:0]        inv_rest_density;

  // Sequencer and request
  st_t                state;
  st_t                state_next;
  st_t                state_prev;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic               nvalid;
  logic               last_q;

  // Accumulators and working registers
  logic               in_run;
  logic [47:0]        dens;
  logic signed [47:0] gsx;
  logic signed [47:0] gsy;
  logic [63:0]        gsq;
  logic [63:0]        dval;
  logic [63:0]        chain;
  logic [63:0]        wacc;
  logic [63:0]        h2;
  logic [63:0]        r2;
  logic [31:0]        root;
  logic [46:0]        gxm;
  logic [46:0]        gym;
  logic [62:0]        num;
  logic               neg_c;
  logic               qovf;

  // Output register
  logic               out_valid;
  logic [31:0]        out_density;
  logic [31:0]        out_lambda;
  logic               out_free;

  // Arithmetic unit hookup
  arith_ctl_t         actl;
  logic               is_op;
  logic [127:0]       a_op;
  logic [63:0]        b_op;
  logic               adone;
  logic [63:0]        ares;
  logic               ahi_nz;

  // Derived values
  logic [32:0]        ax;
  logic [32:0]        ay;
  logic               dx_pos;
  logic               dy_pos;
  logic [31:0]        hr;
  logic [47:0]        gax;
  logic [47:0]        gay;
  logic [48:0]        dens_sum;
  logic [47:0]        dens_add;
  logic [63:0]        den_v;
  logic [32:0]        mag;
  logic [32:0]        mag_neg;
  logic [31:0]        lam_v;
  logic [31:0]        dens_out;

  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  function automatic logic signed [47:0] add_grad(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return s[47:0];
  endfunction

  sdl_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk       (clk),
    .rst       (rst),
    .ctl       (actl),
    .opa       (a_op),
    .opb       (b_op),
    .done      (adone),
    .res       (ares),
    .res_hi_nz (ahi_nz)
  );

  // Distances, magnitudes and the finished result
  always_comb begin
    ax       = dx[32] ? (~dx + 33'd1) : dx;
    ay       = dy[32] ? (~dy + 33'd1) : dy;
    dx_pos   = !dx[32] && (dx != '0);
    dy_pos   = !dy[32] && (dy != '0);
    hr       = ({1'b0, radius} > root) ? ({1'b0, radius} - root) : '0;
    gax      = gsx[47] ? (~gsx + 48'd1) : gsx;
    gay      = gsy[47] ? (~gsy + 48'd1) : gsy;
    dens_sum = {1'b0, dens} + {1'b0, ares[47:0]};
    dens_add = dens_sum[48] ? '1 : dens_sum[47:0];
    den_v    = add_sat64(ares, ONE_Q);
    if (den_v > BIG62) den_v = BIG62;
    mag      = (qovf || chain[63:32] != '0) ? 33'h1_0000_0000 : {1'b0, chain[31:0]};
    mag_neg  = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
    if (neg_c) begin
      lam_v = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      lam_v = 32'd0 - mag_neg[31:0];
    end
    dens_out = (dens > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : dens[31:0];
    out_free = !out_valid || result.ready;
  end

  // Pick the operation and operands of each step
  always_comb begin
    is_op    = 1'b1;
    actl.op  = OP_MUL;
    actl.sh  = SH_0;
    actl.cap = CAP_FULL;
    a_op     = '0;
    b_op     = '0;
    unique case (state)
      ST_SEED, ST_H2: begin
        a_op = 128'(radius);
        b_op = 64'(radius);
      end
      ST_P1: begin
        a_op = 128'(dval); b_op = dval; actl.sh = SH_2F;
      end
      ST_P2: begin
        a_op = 128'(chain); b_op = dval; actl.sh = SH_2F;
      end
      ST_P3: begin
        a_op = 128'(chain); b_op = 64'(poly6_coef); actl.sh = SH_24F;
      end
      ST_P4: begin
        a_op = 128'(chain); b_op = 64'(mass_coef);
        actl.sh = SH_24; actl.cap = CAP_DENS;
      end
      ST_RX: begin
        a_op = 128'(ax); b_op = 64'(ax);
      end
      ST_RY: begin
        a_op = 128'(ay); b_op = 64'(ay);
      end
      ST_SQRT: begin
        actl.op = OP_SQRT; a_op = 128'(r2);
      end
      ST_HR: begin
        a_op = 128'(hr); b_op = 64'(hr);
      end
      ST_SPK: begin
        a_op = 128'(chain); b_op = 64'(spiky_coef); actl.sh = SH_24;
      end
      ST_DIV: begin
        actl.op = OP_DIV; a_op = 128'(chain); b_op = 64'(root) + 64'd1;
      end
      ST_GX: begin
        a_op = 128'(chain); b_op = 64'(ax); actl.sh = SH_F; actl.cap = CAP_GRAD;
      end
      ST_GY: begin
        a_op = 128'(chain); b_op = 64'(ay); actl.sh = SH_F; actl.cap = CAP_GRAD;
      end
      ST_SQX: begin
        a_op = 128'(gxm); b_op = 64'(gxm); actl.sh = SH_F;
      end
      ST_SQY: begin
        a_op = 128'(gym); b_op = 64'(gym); actl.sh = SH_F;
      end
      ST_LPROD: begin
        a_op = 128'(dens); b_op = 64'(inv_rest_density);
        actl.sh = SH_24; actl.cap = CAP_BIG;
      end
      ST_LSX: begin
        a_op = 128'(gax); b_op = 64'(gax); actl.sh = SH_F;
      end
      ST_LSY: begin
        a_op = 128'(gay); b_op = 64'(gay); actl.sh = SH_F;
      end
      ST_LINV: begin
        a_op = 128'(inv_rest_density); b_op = 64'(inv_rest_density); actl.sh = SH_24;
      end
      ST_LDEN: begin
        a_op = 128'(wacc); b_op = chain; actl.sh = SH_24;
      end
      ST_LDIV: begin
        actl.op = OP_DIV; a_op = 128'(num) << FRAC_BITS; b_op = chain;
      end
      default: is_op = 1'b0;
    endcase
    actl.start = is_op && (state != state_prev);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item.valid) state_next = in_run ? ST_NB : ST_SEED;
      ST_SEED:  if (adone) state_next = ST_P1;
      ST_P1:    if (adone) state_next = ST_P2;
      ST_P2:    if (adone) state_next = ST_P3;
      ST_P3:    if (adone) state_next = ST_P4;
      ST_P4:    if (adone) state_next = in_run ? ST_SQRT : ST_NB;
      ST_NB: begin
        if (!nvalid || ax > {2'b0, radius} || ay > {2'b0, radius}) begin
          state_next = ST_LAST;
        end else begin
          state_next = ST_H2;
        end
      end
      ST_H2:    if (adone) state_next = ST_RX;
      ST_RX:    if (adone) state_next = ST_RY;
      ST_RY:    if (adone) state_next = ST_CMP;
      ST_CMP:   state_next = (r2 > h2) ? ST_LAST : ST_P1;
      ST_SQRT:  if (adone) state_next = ST_HR;
      ST_HR:    if (adone) state_next = ST_SPK;
      ST_SPK:   if (adone) state_next = ST_DIV;
      ST_DIV:   if (adone) state_next = ST_GX;
      ST_GX:    if (adone) state_next = ST_GY;
      ST_GY:    if (adone) state_next = ST_SQX;
      ST_SQX:   if (adone) state_next = ST_SQY;
      ST_SQY:   if (adone) state_next = ST_ACC;
      ST_ACC:   state_next = ST_LAST;
      ST_LAST:  state_next = last_q ? ST_LPROD : ST_IDLE;
      ST_LPROD: if (adone) state_next = ST_LSX;
      ST_LSX:   if (adone) state_next = ST_LSY;
      ST_LSY:   if (adone) state_next = ST_LINV;
      ST_LINV:  if (adone) state_next = ST_LDEN;
      ST_LDEN:  if (adone) state_next = ST_LDIV;
      ST_LDIV:  if (adone) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State, run flag and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      state_prev <= ST_IDLE;
      in_run     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      state_prev <= state;
      if (state == ST_P4 && adone && !in_run) in_run <= 1'b1;
      if (state == ST_OUT && out_free) begin
        in_run    <= 1'b0;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius           <= 31'd65536;
      poly6_coef       <= '0;
      spiky_coef       <= '0;
      mass_coef        <= 32'd16777216;
      inv_rest_density <= 32'd16777216;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RADIUS:  radius           <= cfg_data[30:0];
        REG_POLY6:   poly6_coef       <= cfg_data;
        REG_SPIKY:   spiky_coef       <= cfg_data;
        REG_MASS:    mass_coef        <= cfg_data;
        REG_INV_RHO: inv_rest_density <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Capture the request and each step's result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item.valid) begin
      dx     <= {item.pos_x[31], item.pos_x} - {item.neighbor_x[31], item.neighbor_x};
      dy     <= {item.pos_y[31], item.pos_y} - {item.neighbor_y[31], item.neighbor_y};
      nvalid <= item.neighbor_valid;
      last_q <= item.last;
    end
    if (state == ST_CMP) dval <= h2 - r2;
    if (state == ST_ACC) begin
      gsx <= add_grad(gsx, dx_pos ? -$signed({1'b0, gxm}) : $signed({1'b0, gxm}));
      gsy <= add_grad(gsy, dy_pos ? -$signed({1'b0, gym}) : $signed({1'b0, gym}));
      gsq <= add_sat64(gsq, wacc);
    end
    if (state == ST_OUT && out_free) begin
      out_density <= dens_out;
      out_lambda  <= lam_v;
    end
    if (adone) begin
      unique case (state)
        ST_SEED:             dval <= ares;
        ST_P1, ST_P2, ST_P3: chain <= ares;
        ST_P4: begin
          if (!in_run) begin
            dens <= ares[47:0];
            gsx  <= '0;
            gsy  <= '0;
            gsq  <= '0;
          end else begin
            dens <= dens_add;
          end
        end
        ST_H2:   h2 <= ares;
        ST_RX:   wacc <= ares;
        ST_RY:   r2 <= wacc + ares;
        ST_SQRT: root <= ares[31:0];
        ST_HR, ST_SPK, ST_DIV: chain <= ares;
        ST_GX:   gxm <= ares[46:0];
        ST_GY:   gym <= ares[46:0];
        ST_SQX:  wacc <= ares;
        ST_SQY:  wacc <= add_sat64(wacc, ares);
        ST_LPROD: begin
          neg_c <= (ares < ONE_Q);
          num   <= (ares < ONE_Q) ? 63'(ONE_Q - ares) : 63'(ares - ONE_Q);
        end
        ST_LSX:  wacc <= ares;
        ST_LSY:  wacc <= add_sat64(wacc, ares);
        ST_LINV: begin
          chain <= ares;
          wacc  <= add_sat64(wacc, gsq);
        end
        ST_LDEN: chain <= den_v;
        ST_LDIV: begin
          chain <= ares;
          qovf  <= ahi_nz;
        end
        default: ;
      endcase
    end
  end

  assign item.ready     = (state == ST_IDLE);
  assign result.valid   = out_valid;
  assign result.density = out_density;
  assign result.lambda  = out_lambda;

endmodule

/* hw/rtl/sdl_checker.sv */
// Port-level checks of the SPH density and lambda block, bound to the top level.
module sdl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_density,
  input logic [31:0] out_lambda
);

  // A taken request keeps the block busy before the next one can be taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken while previous one still in work");

  // A result only appears out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work behind it");

  // Reset drops the result and opens the request side
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset left block busy or result pending");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_density) && $stable(out_lambda))
    else $error("stalled result changed");

endmodule

bind sph_density_lambda sdl_checker u_sdl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_density (result.density),
  .out_lambda  (result.lambda)
);

/* tb/tb_sph_density_lambda.sv */
// Self-checking testbench for the SPH density and lambda block.
`timescale 1ns / 100ps

module tb_sph_density_lambda;
  import sdl_pkg::*;

  localparam int FB = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FB;
  localparam int IDLE_PCT = 27;
  localparam int SETTLE_CYCLES = 2500;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam longint GMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint GMIN = -64'sh8000_0000_0000;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic               nv;
    logic               last;
  } req_t;

  typedef struct {
    logic        [31:0] density;
    logic signed [31:0] lambda;
  } res_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  sdl_item_if item ();
  sdl_result_if result ();

  sph_density_lambda #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the configuration registers
  logic [63:0] radius_m, poly6_m, spiky_m, mass_m, inv_rho_m;
  // Mirror of the particle accumulators
  logic        run_open;
  logic [63:0] dens_acc;
  longint      grad_x_acc, grad_y_acc;
  logic [63:0] grad_sq_acc;

  res_t   expected_q[$];
  bit     no_idle;
  int     errors = 0;
  int     n_results = 0;
  int     n_reqs, n_reach, n_settings;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Saturating arithmetic helpers
  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh,
                                          logic [63:0] cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    if (p > {64'd0, cap}) return cap;
    return p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, cap}) return cap;
    return s[63:0];
  endfunction

  function automatic longint add_grad(longint a, longint b);
    longint s;
    s = a + b;
    if (s > GMAX) return GMAX;
    if (s < GMIN) return GMIN;
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // mass * poly6 * d^3, d in Q.2F
  function automatic logic [63:0] poly6_density(logic [63:0] d);
    logic [63:0] t;
    t = mul_sat(d, d, 2 * FB, MAX64);
    t = mul_sat(t, d, 2 * FB, MAX64);
    t = mul_sat(t, poly6_m, COEF_FRAC + FB, MAX64);
    return mul_sat(t, mass_m, COEF_FRAC, MAX48);
  endfunction

  // Add one neighbor's density and spiky gradient terms
  function automatic bit accumulate_neighbor(longint dx, longint dy);
    logic [63:0] ax, ay, h, h2, r2, r, hr, s, g, gxm, gym, sq;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    h = radius_m;
    if (ax > h || ay > h) return 1'b0;
    h2 = h * h;
    r2 = ax * ax + ay * ay;
    if (r2 > h2) return 1'b0;
    dens_acc = add_sat(dens_acc, poly6_density(h2 - r2), MAX48);
    r = int_sqrt(r2);
    hr = h > r ? h - r : 0;
    s = mul_sat(hr * hr, spiky_m, COEF_FRAC, MAX64);
    g = s / (r + 1);
    gxm = mul_sat(g, ax, FB, MAX47);
    gym = mul_sat(g, ay, FB, MAX47);
    grad_x_acc = add_grad(grad_x_acc, dx > 0 ? -longint'(gxm) : longint'(gxm));
    grad_y_acc = add_grad(grad_y_acc, dy > 0 ? -longint'(gym) : longint'(gym));
    sq = add_sat(mul_sat(gxm, gxm, FB, MAX64), mul_sat(gym, gym, FB, MAX64), MAX64);
    grad_sq_acc = add_sat(grad_sq_acc, sq, MAX64);
    return 1'b1;
  endfunction

  function automatic logic [31:0] constraint_lambda();
    logic [63:0] prod, num, ax, ay, sumc, inv2, den, q, rem, mag;
    bit neg_c;
    prod = mul_sat(dens_acc, inv_rho_m, COEF_FRAC, BIG62);
    neg_c = prod < ONE_Q;
    num = neg_c ? ONE_Q - prod : prod - ONE_Q;
    ax = grad_x_acc < 0 ? -grad_x_acc : grad_x_acc;
    ay = grad_y_acc < 0 ? -grad_y_acc : grad_y_acc;
    sumc = add_sat(mul_sat(ax, ax, FB, MAX64), mul_sat(ay, ay, FB, MAX64), MAX64);
    inv2 = (inv_rho_m * inv_rho_m) >> COEF_FRAC;
    sumc = add_sat(sumc, grad_sq_acc, MAX64);
    den = add_sat(mul_sat(sumc, inv2, COEF_FRAC, MAX64), ONE_Q, BIG62);
    q = num / den;
    if (q >= (64'd1 << (32 - FB))) begin
      mag = 64'd1 << 32;
    end else begin
      rem = num - q * den;
      mag = q;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        mag = mag << 1;
        if (rem >= den) begin
          rem = rem - den;
          mag[0] = 1'b1;
        end
      end
    end
    if (neg_c) begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return 32'd0 - mag[31:0];
  endfunction

  // Advance the particle state by one accepted request
  function automatic void predict_request(req_t r);
    res_t e;
    if (!run_open) begin
      dens_acc = poly6_density(radius_m * radius_m);
      grad_x_acc = 0;
      grad_y_acc = 0;
      grad_sq_acc = 0;
      run_open = 1'b1;
    end
    if (r.nv)
      n_reach += accumulate_neighbor(longint'(r.cx) - longint'(r.nx),
                                     longint'(r.cy) - longint'(r.ny));
    if (r.last) begin
      e.density = dens_acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : dens_acc[31:0];
      e.lambda = constraint_lambda();
      expected_q.push_back(e);
      run_open = 1'b0;
    end
  endfunction

  task automatic note_fail(string msg);
    errors++;
    if (errors <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Check each result against the oldest expectation; stall at random
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          note_fail($sformatf("unexpected result density=%h lambda=%h",
                              result.density, result.lambda));
        end else begin
          res_t e;
          e = expected_q.pop_front();
          if (result.density !== e.density)
            note_fail($sformatf("density exp %h got %h", e.density, result.density));
          if (result.lambda !== e.lambda)
            note_fail($sformatf("lambda exp %h got %h", e.lambda, result.lambda));
        end
      end
      result.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_q.size());
      $display("tb_sph_density_lambda: FAIL");
      $finish;
    end
  end

  // Send one request, idling at random first
  task automatic send_req(req_t r);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.pos_x <= r.cx;
    item.pos_y <= r.cy;
    item.neighbor_x <= r.nx;
    item.neighbor_y <= r.ny;
    item.neighbor_valid <= r.nv;
    item.last <= r.last;
    do @(posedge clk); while (!item.ready);
    predict_request(r);
    n_reqs++;
  endtask

  task automatic wait_drained();
    item.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Write all registers once the block has gone idle
  task automatic load_config(logic [30:0] h, logic [31:0] p6, logic [31:0] sp,
                             logic [31:0] m, logic [31:0] ir);
    logic [31:0] vals[5];
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    vals = '{{1'b0, h}, p6, sp, m, ir};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    radius_m = h;
    poly6_m = p6;
    spiky_m = sp;
    mass_m = m;
    inv_rho_m = ir;
    n_settings++;
  endtask

  function automatic req_t mk_req(longint cx, longint cy, longint dx, longint dy,
                                  logic nv, logic last);
    req_t r;
    r.cx = cx[31:0];
    r.cy = cy[31:0];
    r.nx = 32'(cx - dx);
    r.ny = 32'(cy - dy);
    r.nv = nv;
    r.last = last;
    return r;
  endfunction

  // Random offset within the radius, sometimes exactly on it
  function automatic longint reach_offset();
    longint o;
    o = ($urandom_range(0, 7) == 0) ? radius_m : $urandom_range(0, radius_m[31:0]);
    return $urandom_range(0, 1) ? -o : o;
  endfunction

  // One particle run of random shape
  task automatic random_run();
    int n;
    longint cx, cy;
    req_t r;
    n = $urandom_range(1, 7);
    cx = $signed($urandom());
    cy = $signed($urandom());
    for (int i = 0; i < n; i++) begin
      int kind;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        cx = $signed($urandom());
        cy = $signed($urandom());
      end
      if (kind < 65) begin
        r = mk_req(cx, cy, reach_offset(), reach_offset(), 1'b1, i == n - 1);
      end else if (kind < 80) begin
        r = mk_req(cx, cy, radius_m + $urandom_range(1, 1000), reach_offset(),
                   1'b1, i == n - 1);
        if ($urandom_range(0, 1)) begin
          logic signed [31:0] t;
          t = r.nx; r.nx = r.ny; r.ny = t;
          t = r.cx; r.cx = r.cy; r.cy = t;
        end
      end else begin
        r.cx = $urandom(); r.cy = $urandom();
        r.nx = $urandom(); r.ny = $urandom();
        r.nv = kind < 90 ? 1'b0 : 1'b1;
        r.last = i == n - 1;
      end
      send_req(r);
    end
  endtask

  task automatic random_runs(int n_items);
    int start;
    start = n_reqs;
    while (n_reqs - start < n_items) random_run();
  endtask

  // Reset values: zero coefficients leave density and gradients at zero
  task automatic test_reset_values();
    send_req(mk_req(0, 0, 0, 0, 1'b0, 1'b1));
    send_req(mk_req(100, -100, 50, 20, 1'b1, 1'b0));
    send_req(mk_req(100, -100, -70, 0, 1'b1, 1'b1));
  endtask

  // Edge cases at a unit radius with realistic coefficients
  task automatic test_directed_cases();
    longint h;
    load_config(31'd65536, 32'd21360000, 32'd160200000, 32'd16777216, 32'h0004_0000);
    h = radius_m;
    // last with no neighbors
    send_req(mk_req(1000, 2000, 0, 0, 1'b0, 1'b1));
    // coincident, on the radius, diagonal outside, axis outside, center moves
    send_req(mk_req(5000, 7000, 0, 0, 1'b1, 1'b0));
    send_req(mk_req(5000, 7000, h, 0, 1'b1, 1'b0));
    send_req(mk_req(5000, 7000, 0, -h, 1'b1, 1'b0));
    send_req(mk_req(5000, 7000, h, h, 1'b1, 1'b0));
    send_req(mk_req(5000, 7000, h + 1, 0, 1'b1, 1'b0));
    send_req(mk_req(-9000, 300, -h / 2, h / 3, 1'b1, 1'b0));
    send_req(mk_req(-9000, 300, 1, -1, 1'b0, 1'b1));
    // position extremes
    send_req(mk_req(-64'sd2147483648, 64'sd2147483647, -64'sd4294967295, 0, 1'b1, 1'b1));
    send_req(mk_req(64'sd2147483647, -64'sd2147483648, 100, -100, 1'b1, 1'b1));
    send_req(mk_req(-64'sd2147483648, -64'sd2147483648, -200, -300, 1'b1, 1'b1));
    send_req(mk_req(-1, -1, 1, 1, 1'b1, 1'b1));
  endtask

  // Saturation at the largest radius and coefficients, then the smallest
  task automatic test_extreme_config();
    longint h;
    load_config(31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    h = radius_m;
    send_req(mk_req(0, 0, 0, 0, 1'b0, 1'b1));
    send_req(mk_req(-64'sd2147483648, 0, -h, 1, 1'b1, 1'b0));
    send_req(mk_req(12345, 0, 3, -4, 1'b1, 1'b1));
    random_runs(40);
    load_config(31'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_req(mk_req(7, 7, 1, 1, 1'b1, 1'b1));
    random_runs(40);
  endtask

  // Random runs over several register settings
  task automatic test_random_settings();
    load_config(31'd65536, 32'd21360000, 32'd160200000, 32'd16777216, 32'h0004_0000);
    random_runs(250);
    load_config($urandom_range(1, 31'h7FFF_FFFF), $urandom(), $urandom(), $urandom(),
                $urandom());
    random_runs(150);
    // stretch with both sides always ready
    no_idle = 1'b1;
    load_config(31'd131072, 32'd500000, 32'd900000000, 32'd33554432, 32'h0100_0000);
    random_runs(250);
    no_idle = 1'b0;
    load_config($urandom_range(1, 300), $urandom(), $urandom(), $urandom(), $urandom());
    random_runs(150);
  endtask

  // Hold the sender until every result is back, then resume
  task automatic test_drain_pause();
    load_config(31'd32768, 32'd3000000000, 32'd40000000, 32'd8388608, 32'h0080_0000);
    random_runs(100);
    wait_drained();
    random_runs(150);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item.valid = 1'b0;
    item.pos_x = '0;
    item.pos_y = '0;
    item.neighbor_x = '0;
    item.neighbor_y = '0;
    item.neighbor_valid = 1'b0;
    item.last = 1'b0;
    no_idle = 1'b0;
    n_reqs = 0;
    n_reach = 0;
    n_settings = 0;
    radius_m = 64'd65536;
    poly6_m = 0;
    spiky_m = 0;
    mass_m = 64'd16777216;
    inv_rho_m = 64'd16777216;
    run_open = 1'b0;
    dens_acc = 0;
    grad_x_acc = 0;
    grad_y_acc = 0;
    grad_sq_acc = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed_cases();
    test_extreme_config();
    test_random_settings();
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d neighbors within reach) and %0d results",
             n_reqs, n_reach, n_results);
    $display("across %0d register settings; %0d mismatches", n_settings, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_sph_density_lambda: PASS");
    end else begin
      $display("tb_sph_density_lambda: FAIL");
    end
    $finish;
  end

endmodule
